>>> rtl/bitmap_page_run_allocator_assert.svh
// Assertion macros for the page run allocator checker.
`ifndef BITMAP_PAGE_RUN_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_RUN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while dis is high.
`define BPRA_ASSERT_IMPLY(label, clk, dis, a, b) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) \
        else $error("allocator assertion failed");

// Next-cycle implication, disabled while dis is high.
`define BPRA_ASSERT_NEXT(label, clk, dis, a, b) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) \
        else $error("allocator assertion failed");

`endif

>>> rtl/bpra_pkg.sv
// Shared constants, types and mask helper for the page run allocator.
package bpra_pkg;

    localparam int NUM_PAGES = 32768;
    localparam int WORD_W    = 64;
    localparam int WORDS     = NUM_PAGES / WORD_W;
    localparam int ADDR_W    = $clog2(WORDS);
    localparam int WB        = $clog2(WORD_W);
    localparam int PAGE_W    = 15;
    localparam int COUNT_W   = 16;
    localparam int CNT_W     = $clog2(NUM_PAGES) + 2;
    localparam int CHUNK     = 8;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_FAULT   = 2'd2,
        ST_BAD     = 2'd3
    } status_t;

    // Bits of word wa whose page lies in [lo, hi).
    function automatic logic [WORD_W-1:0] run_mask(input logic [ADDR_W-1:0] wa,
                                                   input logic [CNT_W-1:0] lo,
                                                   input logic [CNT_W-1:0] hi);
        logic [WORD_W-1:0] m;
        logic [CNT_W-1:0]  p;
        for (int j = 0; j < WORD_W; j++) begin
            p    = CNT_W'({wa, WB'(j)});
            m[j] = (p >= lo) && (p < hi);
        end
        return m;
    endfunction

endpackage

>>> rtl/bpra_ram.sv
// Generic simple dual-port RAM with registered read.
module bpra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/bitmap_page_run_allocator.sv
// First-fit page run allocator over a used/free bitmap held in one RAM.
//
// Requests enter on the s_ channel (s_tuser = command: 0 allocate, 1 free);
// one result per request leaves on the m_ channel (m_tuser = status).
// Only one request is in flight; s_tready is high while the block is idle,
// even when a finished result still waits in the output register.
// A bad request answers without touching the bitmap. An allocate scans the
// bitmap eight pages per cycle within a word, with a RAM read state between
// 64-page words, over up to 32768 pages. Marking a run then checks each word
// (read, then check) and writes each word back (read, then write), through
// the single read port of the bitmap RAM.
// After reset the bitmap RAM is cleared one word per cycle, all 512 words,
// while s_tready stays low; the reserved count returns to one page.
// When m_tready is low a result holds in the output register and the
// next finished result waits in the controller until it is taken.
module bitmap_page_run_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // page_index[14:0], count[30:15], zero
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // start_page[14:0], grown_pages[30:15], zero
    output logic [1:0]  m_tuser    // status
);

    localparam int CW = bpra_pkg::CNT_W;
    localparam int AW = bpra_pkg::ADDR_W;
    localparam int WW = bpra_pkg::WORD_W;
    localparam int WB = bpra_pkg::WB;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SC_RD, S_SC_PROC, S_CHK_RD, S_CHK_EV,
        S_WR_RD, S_WR_EV, S_DONE
    } state_t;

    state_t                    state_reg;
    logic [AW-1:0]             clr_reg;
    logic                      cmd_reg;
    logic [CW-1:0]             want_reg;
    logic [CW-1:0]             i_reg;
    logic [CW-1:0]             have_reg;
    logic [CW-1:0]             ret_reg;
    logic [CW-1:0]             reserved_reg;
    logic [CW-1:0]             begin_reg;
    logic [CW-1:0]             end_reg;
    logic                      mark_v_reg;
    logic [CW-1:0]             grow_reg;
    logic [AW-1:0]             wa_reg;
    bpra_pkg::status_t         res_status_reg;
    logic [CW-1:0]             res_start_reg;
    logic [CW-1:0]             res_grown_reg;
    logic                      m_tvalid_reg;
    logic [31:0]               m_tdata_reg;
    logic [1:0]                m_tuser_reg;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [WW-1:0]             ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [WW-1:0]             ram_rdata;

    logic [CW-1:0]             have_next;
    logic [CW-1:0]             ret_next;
    logic [CW-1:0]             i_next;
    logic                      ev_found;
    logic                      ev_grow;
    logic [bpra_pkg::CHUNK-1:0] chunk_bits;
    logic [WW-1:0]             mask;
    logic                      mark_bad;
    logic [CW-1:0]             end_m1;
    logic [AW-1:0]             last_wa;
    logic [CW-1:0]             in_page;
    logic [CW-1:0]             in_count;

    bpra_ram #(.WIDTH(WW), .DEPTH(bpra_pkg::WORDS)) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_page  = CW'(s_tdata[bpra_pkg::PAGE_W-1:0]);
    assign in_count = CW'(s_tdata[bpra_pkg::PAGE_W +: bpra_pkg::COUNT_W]);
    assign end_m1   = end_reg - CW'(1);
    assign last_wa  = end_m1[WB +: AW];
    assign mask     = bpra_pkg::run_mask(wa_reg, begin_reg, end_reg);
    assign mark_bad = mark_v_reg ? (|(ram_rdata & mask)) : (|(~ram_rdata & mask));

    // Scan eight pages of the current word; stop at the first event.
    always_comb begin
        logic [CW-1:0] p;
        chunk_bits = ram_rdata[i_reg[WB-1:0] +: bpra_pkg::CHUNK];
        have_next  = have_reg;
        ret_next   = ret_reg;
        ev_found   = 1'b0;
        ev_grow    = 1'b0;
        for (int k = 0; k < bpra_pkg::CHUNK; k++) begin
            p = i_reg + CW'(k);
            if (!ev_found && !ev_grow) begin
                if (p >= reserved_reg) begin
                    ev_grow = 1'b1;
                end else if (chunk_bits[k]) begin
                    have_next = '0;
                    ret_next  = p + CW'(1);
                end else begin
                    have_next = have_next + CW'(1);
                    if (have_next == want_reg) begin
                        ev_found = 1'b1;
                    end
                end
            end
        end
        i_next = i_reg + CW'(bpra_pkg::CHUNK);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wa_reg;
        ram_wdata = mark_v_reg ? (ram_rdata | mask) : (ram_rdata & ~mask);
        ram_re    = 1'b0;
        ram_raddr = wa_reg;
        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            S_SC_RD: begin
                ram_re    = 1'b1;
                ram_raddr = i_reg[WB +: AW];
            end
            S_CHK_RD, S_WR_RD: ram_re = 1'b1;
            S_WR_EV: ram_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            reserved_reg <= CW'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            // in S_DONE the output register is handled below
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(bpra_pkg::WORDS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg        <= s_tuser;
                        want_reg       <= in_count;
                        res_start_reg  <= '0;
                        res_grown_reg  <= '0;
                        grow_reg       <= '0;
                        i_reg          <= '0;
                        have_reg       <= '0;
                        ret_reg        <= '0;
                        begin_reg      <= in_page;
                        end_reg        <= in_page + in_count;
                        wa_reg         <= in_page[WB +: AW];
                        mark_v_reg     <= 1'b0;
                        res_status_reg <= bpra_pkg::ST_BAD;
                        if (in_count == '0) begin
                            state_reg <= S_DONE;
                        end else if (s_tuser == bpra_pkg::CMD_FREE) begin
                            if (in_page + in_count > CW'(bpra_pkg::NUM_PAGES)) begin
                                state_reg <= S_DONE;
                            end else begin
                                state_reg <= S_CHK_RD;
                            end
                        end else if (in_count > CW'(bpra_pkg::NUM_PAGES)) begin
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_SC_RD;
                        end
                    end
                end
                S_SC_RD: state_reg <= S_SC_PROC;
                S_SC_PROC: begin
                    have_reg <= have_next;
                    ret_reg  <= ret_next;
                    i_reg    <= i_next;
                    priority if (ev_found) begin
                        begin_reg  <= ret_next;
                        end_reg    <= ret_next + want_reg;
                        wa_reg     <= ret_next[WB +: AW];
                        mark_v_reg <= 1'b1;
                        state_reg  <= S_CHK_RD;
                    end else if (ev_grow) begin
                        if (ret_next + want_reg > CW'(bpra_pkg::NUM_PAGES)) begin
                            res_status_reg <= bpra_pkg::ST_NOSPACE;
                            state_reg      <= S_DONE;
                        end else begin
                            begin_reg  <= ret_next;
                            end_reg    <= ret_next + want_reg;
                            wa_reg     <= ret_next[WB +: AW];
                            mark_v_reg <= 1'b1;
                            grow_reg   <= want_reg - have_next;
                            state_reg  <= S_CHK_RD;
                        end
                    end else if (i_next >= CW'(bpra_pkg::NUM_PAGES)) begin
                        res_status_reg <= bpra_pkg::ST_NOSPACE;
                        state_reg      <= S_DONE;
                    end else if (i_next[WB-1:0] == '0) begin
                        state_reg <= S_SC_RD;
                    end else begin
                        state_reg <= S_SC_PROC;
                    end
                end
                S_CHK_RD: state_reg <= S_CHK_EV;
                S_CHK_EV: begin
                    if (mark_bad) begin
                        res_status_reg <= bpra_pkg::ST_FAULT;
                        state_reg      <= S_DONE;
                    end else if (wa_reg == last_wa) begin
                        wa_reg    <= begin_reg[WB +: AW];
                        state_reg <= S_WR_RD;
                    end else begin
                        wa_reg    <= wa_reg + AW'(1);
                        state_reg <= S_CHK_RD;
                    end
                end
                S_WR_RD: state_reg <= S_WR_EV;
                S_WR_EV: begin
                    if (wa_reg == last_wa) begin
                        res_status_reg <= bpra_pkg::ST_OK;
                        reserved_reg   <= reserved_reg + grow_reg;
                        res_grown_reg  <= grow_reg;
                        res_start_reg  <= (cmd_reg == bpra_pkg::CMD_ALLOC) ? begin_reg : '0;
                        state_reg      <= S_DONE;
                    end else begin
                        wa_reg    <= wa_reg + AW'(1);
                        state_reg <= S_WR_RD;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= {1'b0,
                                         res_grown_reg[bpra_pkg::COUNT_W-1:0],
                                         res_start_reg[bpra_pkg::PAGE_W-1:0]};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/bpra_checker.sv
// Port-level assertion checker for the page run allocator, with its bind.
`include "bitmap_page_run_allocator_assert.svh"

module bpra_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `BPRA_ASSERT_NEXT(a_reset_no_result, aclk, 1'b0, !aresetn, !m_tvalid)
    `BPRA_ASSERT_NEXT(a_result_holds, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid)
    `BPRA_ASSERT_IMPLY(a_fail_zero, aclk, !aresetn,
        m_tvalid && (m_tuser != bpra_pkg::ST_OK), m_tdata == 32'd0)
    `BPRA_ASSERT_NEXT(a_one_in_flight, aclk, !aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind bitmap_page_run_allocator bpra_checker u_bpra_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
